// ===== rtl/qun_pkg.sv =====
// Shared types and constants for the quad unit normal pipeline.
// No dependencies; used by the square root, divider and top level files.
package qun_pkg;

    // Width of a normalized cross product magnitude; its top bit position.
    localparam int unsigned A_BITS = 31;
    localparam int unsigned A_TOP = A_BITS - 1;

    // Sum of three squared magnitudes and its integer square root.
    localparam int unsigned SUM_BITS = 64;
    localparam int unsigned LEN_BITS = SUM_BITS / 2;
    localparam int unsigned ROOT_STEPS = SUM_BITS / 2;

    // Item context that travels alongside the length computation.
    typedef struct packed {
        logic [2:0][A_BITS-1:0] mag;
        logic [2:0]             neg;
        logic                   deg;
    } qun_pay_t;

endpackage

// ===== rtl/quad_unit_normal_core.sv =====
// Stages from input transfer to result:
// 7 front stages, 32 square root stages, FRAC_BITS + 1 divider stages, 1 output register.
// Throughput: one item per cycle unless the output stalls; every stage advances on its own when the next is free.
// Reset: synchronous, active low; clears all valid bits, the pipeline then holds no items.
// Top level of the quad unit normal pipeline.
// Depends on qun_pkg, qun_isqrt and qun_div.
module quad_unit_normal_core
    import qun_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_ax,
    input  logic signed [COORD_BITS-1:0] s_bx,
    input  logic signed [COORD_BITS-1:0] s_cx,
    input  logic signed [COORD_BITS-1:0] s_dx,
    input  logic signed [COORD_BITS-1:0] s_ay,
    input  logic signed [COORD_BITS-1:0] s_by_coord,
    input  logic signed [COORD_BITS-1:0] s_cy,
    input  logic signed [COORD_BITS-1:0] s_dy,
    input  logic signed [COORD_BITS-1:0] s_az,
    input  logic signed [COORD_BITS-1:0] s_bz,
    input  logic signed [COORD_BITS-1:0] s_cz,
    input  logic signed [COORD_BITS-1:0] s_dz,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [FRAC_BITS+1:0]  m_norm_x,
    output logic signed [FRAC_BITS+1:0]  m_norm_y,
    output logic signed [FRAC_BITS+1:0]  m_norm_z,
    output logic                         m_degenerate
);

    localparam int DW  = COORD_BITS + 1;
    localparam int PW  = 2 * DW;
    localparam int CW  = PW + 1;
    localparam int MW  = 2 * COORD_BITS + 2;
    localparam int PSW = $clog2(MW);
    localparam int NW  = FRAC_BITS + 2;
    localparam int SQW = 2 * A_BITS;

    logic en1, en2, en3, en4, en5, en6, en7, out_en;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;

    // Stage 1: diagonals.
    logic signed [DW-1:0] d1x_reg, d1y_reg, d1z_reg, d2x_reg, d2y_reg, d2z_reg;
    // Stage 2: partial products of the cross product.
    logic signed [PW-1:0] p_reg [6];
    // Stage 3: magnitudes and signs.
    logic signed [CW-1:0] c_next [3];
    logic [2:0][MW-1:0]   m3_reg;
    logic [2:0]           neg3_reg;
    // Stage 4: leading one position of the largest magnitude.
    logic [MW-1:0]        orv;
    logic [PSW-1:0]       pos_next, pos_reg;
    logic [2:0][MW-1:0]   m4_reg;
    logic [2:0]           neg4_reg;
    logic                 deg4_reg;
    // Stage 5: common normalizing shift.
    logic [2:0][A_BITS-1:0] a_next, a5_reg, a6_reg, a7_reg;
    logic [2:0]           neg5_reg, neg6_reg, neg7_reg;
    logic                 deg5_reg, deg6_reg, deg7_reg;
    // Stage 6 and 7: squares and their sum.
    logic [SQW-1:0]       sq_next [3];
    logic [SQW-1:0]       sq_reg  [3];
    logic [SUM_BITS-1:0]  sum_reg;

    qun_pay_t             sq_pay, len_pay;
    logic                 sq_in_ready, len_valid, len_ready;
    logic [LEN_BITS-1:0]  len;
    logic                 dv_valid;
    logic [2:0][FRAC_BITS:0] dv_quo;
    logic [2:0]           dv_neg;
    logic                 dv_deg;

    logic signed [NW-1:0] nx_next, ny_next, nz_next;
    logic signed [NW-1:0] nx_reg, ny_reg, nz_reg;
    logic                 m_valid_reg, deg_out_reg;

    assign out_en = !m_valid_reg || m_ready;
    assign en7 = !v7_reg || sq_in_ready;
    assign en6 = !v6_reg || en7;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
            if (en7) v7_reg <= v6_reg;
            if (out_en) m_valid_reg <= dv_valid;
        end
    end

    always_comb begin
        c_next[0] = CW'(p_reg[0]) - CW'(p_reg[1]);
        c_next[1] = CW'(p_reg[2]) - CW'(p_reg[3]);
        c_next[2] = CW'(p_reg[4]) - CW'(p_reg[5]);
    end

    always_comb begin
        orv = m3_reg[0] | m3_reg[1] | m3_reg[2];
        pos_next = '0;
        for (int i = 0; i < MW; i++) begin
            if (orv[i]) pos_next = PSW'(i);
        end
    end

    // Bring the largest magnitude to exactly A_BITS bits; right shifts truncate.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (pos_reg >= PSW'(A_TOP)) begin
                a_next[i] = A_BITS'(m4_reg[i] >> (pos_reg - PSW'(A_TOP)));
            end else begin
                a_next[i] = A_BITS'(m4_reg[i]) << (PSW'(A_TOP) - pos_reg);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sq_next[i] = SQW'(a5_reg[i]) * SQW'(a5_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            d1x_reg <= DW'(s_cx) - DW'(s_ax);
            d1y_reg <= DW'(s_cy) - DW'(s_ay);
            d1z_reg <= DW'(s_cz) - DW'(s_az);
            d2x_reg <= DW'(s_dx) - DW'(s_bx);
            d2y_reg <= DW'(s_dy) - DW'(s_by_coord);
            d2z_reg <= DW'(s_dz) - DW'(s_bz);
        end
        if (en2) begin
            p_reg[0] <= d1y_reg * d2z_reg;
            p_reg[1] <= d1z_reg * d2y_reg;
            p_reg[2] <= d1z_reg * d2x_reg;
            p_reg[3] <= d1x_reg * d2z_reg;
            p_reg[4] <= d1x_reg * d2y_reg;
            p_reg[5] <= d1y_reg * d2x_reg;
        end
        if (en3) begin
            for (int i = 0; i < 3; i++) begin
                neg3_reg[i] <= c_next[i][CW-1];
                m3_reg[i]   <= c_next[i][CW-1] ? MW'(-c_next[i]) : MW'(c_next[i]);
            end
        end
        if (en4) begin
            pos_reg  <= pos_next;
            m4_reg   <= m3_reg;
            neg4_reg <= neg3_reg;
            deg4_reg <= (orv == '0);
        end
        if (en5) begin
            a5_reg   <= a_next;
            neg5_reg <= neg4_reg;
            deg5_reg <= deg4_reg;
        end
        if (en6) begin
            a6_reg   <= a5_reg;
            neg6_reg <= neg5_reg;
            deg6_reg <= deg5_reg;
            for (int i = 0; i < 3; i++) sq_reg[i] <= sq_next[i];
        end
        if (en7) begin
            a7_reg   <= a6_reg;
            neg7_reg <= neg6_reg;
            deg7_reg <= deg6_reg;
            sum_reg  <= SUM_BITS'(sq_reg[0]) + SUM_BITS'(sq_reg[1]) + SUM_BITS'(sq_reg[2]);
        end
    end

    assign sq_pay.mag = a7_reg;
    assign sq_pay.neg = neg7_reg;
    assign sq_pay.deg = deg7_reg;

    qun_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v7_reg),
        .in_ready  (sq_in_ready),
        .in_sum    (sum_reg),
        .in_pay    (sq_pay),
        .out_valid (len_valid),
        .out_ready (len_ready),
        .out_len   (len),
        .out_pay   (len_pay)
    );

    qun_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (len_valid),
        .in_ready  (len_ready),
        .in_len    (len),
        .in_pay    (len_pay),
        .out_valid (dv_valid),
        .out_ready (out_en),
        .out_quo   (dv_quo),
        .out_neg   (dv_neg),
        .out_deg   (dv_deg)
    );

    // A zero cross product forces the normal to zero; the divider output is then meaningless.
    always_comb begin
        nx_next = dv_neg[0] ? -NW'(dv_quo[0]) : NW'(dv_quo[0]);
        ny_next = dv_neg[1] ? -NW'(dv_quo[1]) : NW'(dv_quo[1]);
        nz_next = dv_neg[2] ? -NW'(dv_quo[2]) : NW'(dv_quo[2]);
        if (dv_deg) begin
            nx_next = '0;
            ny_next = '0;
            nz_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en) begin
            nx_reg      <= nx_next;
            ny_reg      <= ny_next;
            nz_reg      <= nz_next;
            deg_out_reg <= dv_deg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_norm_x     = nx_reg;
    assign m_norm_y     = ny_reg;
    assign m_norm_z     = nz_reg;
    assign m_degenerate = deg_out_reg;

`ifndef SYNTHESIS
    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> m_norm_x == '0 && m_norm_y == '0 && m_norm_z == '0)
        else $error("degenerate result with nonzero normal");

    a_nondeg_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_degenerate |-> m_norm_x != '0 || m_norm_y != '0 || m_norm_z != '0)
        else $error("regular result with zero normal");

    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output back pressure");

    a_hold_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_norm_x) && $stable(m_degenerate))
        else $error("stalled result changed");
`endif

endmodule

// ===== rtl/qun_isqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Depends on qun_pkg for widths and the item context type.
module qun_isqrt
    import qun_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SUM_BITS-1:0] in_sum,
    input  qun_pay_t            in_pay,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [LEN_BITS-1:0] out_len,
    output qun_pay_t            out_pay
);

    logic [ROOT_STEPS-1:0] en;
    logic [ROOT_STEPS-1:0] v_reg;
    logic [SUM_BITS-1:0]   rem_reg  [ROOT_STEPS];
    logic [SUM_BITS-1:0]   root_reg [ROOT_STEPS];
    qun_pay_t              pay_reg  [ROOT_STEPS];

    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
        localparam logic [SUM_BITS-1:0] STEP_BIT = SUM_BITS'(1) << (SUM_BITS - 2 - 2 * k);
        logic [SUM_BITS-1:0] rem_in;
        logic [SUM_BITS-1:0] root_in;
        logic [SUM_BITS-1:0] trial;
        logic [SUM_BITS-1:0] rem_next;
        logic [SUM_BITS-1:0] root_next;
        logic                v_in;
        qun_pay_t            pay_in;

        if (k == 0) begin : g_first
            assign rem_in  = in_sum;
            assign root_in = '0;
            assign v_in    = in_valid;
            assign pay_in  = in_pay;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign v_in    = v_reg[k-1];
            assign pay_in  = pay_reg[k-1];
        end

        if (k == ROOT_STEPS - 1) begin : g_last
            assign en[k] = !v_reg[k] || out_ready;
        end else begin : g_mid
            assign en[k] = !v_reg[k] || en[k+1];
        end

        always_comb begin
            trial = root_in + STEP_BIT;
            if (rem_in >= trial) begin
                rem_next  = rem_in - trial;
                root_next = (root_in >> 1) + STEP_BIT;
            end else begin
                rem_next  = rem_in;
                root_next = root_in >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en[k]) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                pay_reg[k]  <= pay_in;
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[ROOT_STEPS-1];
    assign out_len   = root_reg[ROOT_STEPS-1][LEN_BITS-1:0];
    assign out_pay   = pay_reg[ROOT_STEPS-1];

endmodule

// ===== rtl/qun_div.sv =====
// Pipelined restoring divider: three lanes share one divisor, one quotient bit per stage.
// Depends on qun_pkg for the item context type and widths.
module qun_div
    import qun_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [LEN_BITS-1:0]      in_len,
    input  qun_pay_t                 in_pay,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [2:0][FRAC_BITS:0]  out_quo,
    output logic [2:0]               out_neg,
    output logic                     out_deg
);

    localparam int QB = FRAC_BITS + 1;
    localparam int RW = A_BITS + FRAC_BITS + 2;

    logic [QB-1:0]          en;
    logic [QB-1:0]          v_reg;
    logic [2:0][RW-1:0]     rem_reg [QB];
    logic [2:0][QB-1:0]     quo_reg [QB];
    logic [LEN_BITS-1:0]    len_reg [QB];
    logic [2:0]             neg_reg [QB];
    logic                   deg_reg [QB];

    for (genvar j = 0; j < QB; j++) begin : g_step
        localparam int B = QB - 1 - j;
        logic [2:0][RW-1:0] rem_in;
        logic [2:0][QB-1:0] quo_in;
        logic [LEN_BITS-1:0] len_in;
        logic [2:0]          neg_in;
        logic                deg_in;
        logic                v_in;
        logic [RW-1:0]       dvs;
        logic [2:0][RW-1:0]  rem_next;
        logic [2:0][QB-1:0]  quo_next;

        if (j == 0) begin : g_first
            // The rounding offset of half the divisor is folded into the dividend.
            for (genvar i = 0; i < 3; i++) begin : g_lane
                assign rem_in[i] = (RW'(in_pay.mag[i]) << FRAC_BITS) + RW'(in_len >> 1);
            end
            assign quo_in = '0;
            assign len_in = in_len;
            assign neg_in = in_pay.neg;
            assign deg_in = in_pay.deg;
            assign v_in   = in_valid;
        end else begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign quo_in = quo_reg[j-1];
            assign len_in = len_reg[j-1];
            assign neg_in = neg_reg[j-1];
            assign deg_in = deg_reg[j-1];
            assign v_in   = v_reg[j-1];
        end

        if (j == QB - 1) begin : g_last
            assign en[j] = !v_reg[j] || out_ready;
        end else begin : g_mid
            assign en[j] = !v_reg[j] || en[j+1];
        end

        assign dvs = RW'(len_in) << B;

        always_comb begin
            rem_next = rem_in;
            quo_next = quo_in;
            for (int i = 0; i < 3; i++) begin
                if (rem_in[i] >= dvs) begin
                    rem_next[i]    = rem_in[i] - dvs;
                    quo_next[i][B] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (en[j]) begin
                v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[j]) begin
                rem_reg[j] <= rem_next;
                quo_reg[j] <= quo_next;
                len_reg[j] <= len_in;
                neg_reg[j] <= neg_in;
                deg_reg[j] <= deg_in;
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[QB-1];
    assign out_quo   = quo_reg[QB-1];
    assign out_neg   = neg_reg[QB-1];
    assign out_deg   = deg_reg[QB-1];

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for quad_unit_normal_core: random and directed quads,
// unit normals predicted in the testbench and compared per transfer. Depends on the RTL only.
`timescale 1ns / 100ps

module tb_top;

    localparam int CB = 16;
    localparam int FB = 14;
    localparam int NB = FB + 2;
    localparam int RANDOM_QUADS = 2000;
    localparam int QUIET_QUADS = 300;
    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        logic [NB-1:0] nx;
        logic [NB-1:0] ny;
        logic [NB-1:0] nz;
        logic          deg;
    } normal_t;

    typedef logic signed [CB-1:0] coord_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    coord_t s_ax = '0, s_bx = '0, s_cx = '0, s_dx = '0;
    coord_t s_ay = '0, s_by_coord = '0, s_cy = '0, s_dy = '0;
    coord_t s_az = '0, s_bz = '0, s_cz = '0, s_dz = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [NB-1:0] m_norm_x, m_norm_y, m_norm_z;
    logic m_degenerate;

    normal_t expected_normals[$];
    int mismatches = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    bit quiet = 1'b0;
    bit hold_off = 1'b0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    quad_unit_normal_core #(.COORD_BITS(CB), .FRAC_BITS(FB)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_ax(s_ax), .s_bx(s_bx), .s_cx(s_cx), .s_dx(s_dx),
        .s_ay(s_ay), .s_by_coord(s_by_coord), .s_cy(s_cy), .s_dy(s_dy),
        .s_az(s_az), .s_bz(s_bz), .s_cz(s_cz), .s_dz(s_dz),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_norm_x(m_norm_x), .m_norm_y(m_norm_y), .m_norm_z(m_norm_z),
        .m_degenerate(m_degenerate)
    );

    function automatic logic [63:0] root_floor(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // v holds x0..x3, y0..y3, z0..z3.
    function automatic normal_t unit_normal(coord_t v[12]);
        longint d1x, d1y, d1z, d2x, d2y, d2z;
        longint cp[3];
        logic [63:0] mag[3];
        logic [63:0] mx, sum, len, q;
        int rsh, lsh;
        logic [NB-1:0] comp[3];
        normal_t r;
        d1x = v[2] - v[0];
        d1y = v[6] - v[4];
        d1z = v[10] - v[8];
        d2x = v[3] - v[1];
        d2y = v[7] - v[5];
        d2z = v[11] - v[9];
        cp[0] = d1y * d2z - d1z * d2y;
        cp[1] = d1z * d2x - d1x * d2z;
        cp[2] = d1x * d2y - d1y * d2x;
        if (cp[0] == 0 && cp[1] == 0 && cp[2] == 0) begin
            r = '0;
            r.deg = 1'b1;
            return r;
        end
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = cp[i] < 0 ? -cp[i] : cp[i];
            if (mag[i] > mx) mx = mag[i];
        end
        rsh = 0;
        lsh = 0;
        while (mx >= (64'd1 << 31)) begin
            mx = mx >> 1;
            rsh++;
        end
        while (mx < (64'd1 << 30)) begin
            mx = mx << 1;
            lsh++;
        end
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (mag[i] >> rsh) << lsh;
            sum = sum + mag[i] * mag[i];
        end
        len = root_floor(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << FB) + (len >> 1)) / len;
            if (cp[i] < 0) q = -q;
            comp[i] = q[NB-1:0];
        end
        r.nx = comp[0];
        r.ny = comp[1];
        r.nz = comp[2];
        r.deg = 1'b0;
        return r;
    endfunction

    // Valid stays high between back-to-back transfers; it drops only for an idle burst.
    task automatic send_quad(coord_t v[12]);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        {s_ax, s_bx, s_cx, s_dx} <= {v[0], v[1], v[2], v[3]};
        {s_ay, s_by_coord, s_cy, s_dy} <= {v[4], v[5], v[6], v[7]};
        {s_az, s_bz, s_cz, s_dz} <= {v[8], v[9], v[10], v[11]};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_normals.push_back(unit_normal(v));
    endtask

    // Receiver: random stall bursts, always ready in quiet mode, or a long hold-off when requested.
    always @(posedge aclk) begin
        if (!aresetn || hold_off || quiet) begin
            m_ready <= aresetn && !hold_off;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 15) == 0) begin
            m_ready <= 1'b0;
            stall_left <= $urandom_range(0, 17);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        normal_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_norm_x, m_norm_y, m_norm_z, m_degenerate};
            if (expected_normals.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transfer: %h", got);
            end else begin
                want = expected_normals.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d %0d %0d deg %0b, got %0d %0d %0d deg %0b",
                            $signed(want.nx), $signed(want.ny), $signed(want.nz), want.deg,
                            $signed(got.nx), $signed(got.ny), $signed(got.nz), got.deg);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || hold_off) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Directed rows: vertices, then an expected normal where it is obvious.
    typedef struct {
        coord_t  v[12];
        bit      known;
        normal_t want;
    } quad_row_t;

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 5))
            0: return coord_t'(16'h8000);
            1: return coord_t'(16'h7fff);
            2: return coord_t'($urandom_range(0, 7) - 4);
            default: return coord_t'($urandom());
        endcase
    endfunction

    initial begin
        quad_row_t rows[$];
        quad_row_t row;
        coord_t v[12];
        normal_t zero_deg;
        zero_deg = '0;
        zero_deg.deg = 1'b1;

        // All vertices equal: degenerate.
        foreach (row.v[i]) row.v[i] = 0;
        row.known = 1; row.want = zero_deg; rows.push_back(row);
        foreach (row.v[i]) row.v[i] = coord_t'(16'h8000);
        rows.push_back(row);
        foreach (row.v[i]) row.v[i] = coord_t'(16'h7fff);
        rows.push_back(row);
        // Unit square in the xy plane: d1=(1,1,0), d2=(-1,1,0), normal +z.
        row.v = '{0, 1, 1, 0, 0, 0, 1, 1, 0, 0, 0, 0};
        row.known = 1; row.want = '{nx: 0, ny: 0, nz: 16'sd16384, deg: 0};
        rows.push_back(row);
        // Reversed winding gives -z.
        row.v = '{0, 0, 1, 1, 0, 1, 1, 0, 0, 0, 0, 0};
        row.want = '{nx: 0, ny: 0, nz: -16'sd16384, deg: 0};
        rows.push_back(row);
        // Square in the yz plane: normal +x.
        row.v = '{0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 1, 1};
        row.want = '{nx: 16'sd16384, ny: 0, nz: 0, deg: 0};
        rows.push_back(row);
        // Square in the zx plane: normal +y.
        row.v = '{0, 0, 1, 1, 0, 0, 0, 0, 0, 1, 1, 0};
        row.want = '{nx: 0, ny: 16'sd16384, nz: 0, deg: 0};
        rows.push_back(row);
        // Parallel diagonals: degenerate.
        row.v = '{0, 0, 2, 1, 0, 0, 2, 1, 0, 0, 2, 1};
        row.want = zero_deg;
        rows.push_back(row);
        // Extreme spans, checked against the predictor.
        row.known = 0;
        row.v = '{-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767,
                  -32768, 32767, 32767, -32768};
        rows.push_back(row);
        row.v = '{32767, -32768, -32768, 32767, -32768, 32767, 32767, -32768,
                  0, 0, 32767, -32768};
        rows.push_back(row);
        row.v = '{-32768, 0, 32767, 0, 0, -32768, 0, 32767, 1, 2, 3, 4};
        rows.push_back(row);
        row.v = '{1, 0, 0, 0, 0, 0, 1, 0, 0, 1, 0, 0};
        rows.push_back(row);
        row.v = '{-1, -1, -1, -1, 5, -7, 3, 9, -32768, 32767, -2, 11};
        rows.push_back(row);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[r]) begin
            if (rows[r].known && unit_normal(rows[r].v) !== rows[r].want) begin
                mismatches++;
                if (mismatches <= 10) $display("directed row %0d: prediction disagrees", r);
            end
            send_quad(rows[r].v);
        end

        // Sender pauses until every result is back.
        s_valid <= 1'b0;
        while (expected_normals.size() != 0) @(posedge aclk);

        for (int n = 0; n < RANDOM_QUADS; n++) begin
            if (n == 400) begin
                hold_off = 1'b1;
                fork
                    begin
                        repeat (300) @(posedge aclk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            if (n == RANDOM_QUADS - QUIET_QUADS) quiet = 1'b1;
            for (int i = 0; i < 12; i++) v[i] = rand_coord();
            // Some degenerate and planar quads.
            case ($urandom_range(0, 9))
                0: begin
                    for (int i = 0; i < 4; i++) v[8 + i] = v[8];
                end
                1: begin
                    v[2] = v[0] + (v[3] - v[1]) * 2;
                    v[6] = v[4] + (v[7] - v[5]) * 2;
                    v[10] = v[8] + (v[11] - v[9]) * 2;
                end
                default: ;
            endcase
            send_quad(v);
        end

        s_valid <= 1'b0;
        while (expected_normals.size() != 0) @(posedge aclk);
        repeat (70) @(posedge aclk);
        if (mismatches == 0 && expected_normals.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
